>>> src/deq_pkg.sv
// Package for the double-ended queue with running sum.
// Holds field widths, operation codes and status codes; depends on nothing.
package deq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 7;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_LIST       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

>>> src/deq_addr.sv
// Ring address arithmetic for the double-ended queue.
// Computes neighbor, back and tail slots modulo DEPTH; depends on deq_pkg.
module deq_addr #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0]   front,
  input  logic [deq_pkg::CNT_W-1:0]  count,
  input  logic [$clog2(DEPTH)-1:0]   walk,
  output logic [$clog2(DEPTH)-1:0]   front_inc,
  output logic [$clog2(DEPTH)-1:0]   front_dec,
  output logic [$clog2(DEPTH)-1:0]   back_pos,
  output logic [$clog2(DEPTH)-1:0]   tail_pos,
  output logic [$clog2(DEPTH)-1:0]   walk_inc
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int SW = CNT_W + 1;

  logic [SW-1:0] back_sum;
  logic [SW-1:0] tail_sum;

  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign walk_inc  = (walk == IW'(DEPTH - 1)) ? '0 : walk + IW'(1);

  assign back_sum = SW'(front) + SW'(count);
  assign tail_sum = back_sum - SW'(1);

  assign back_pos = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);

endmodule

>>> src/double_ended_queue_with_sum_top.sv
// Top level of the double-ended queue with running sum.
// Holds the slot memory and the control sequencer; uses deq_pkg and deq_addr.
//
// A command word is taken at a rising edge where start is high and busy is
// low. It carries mode and value. Results leave on item, entries, total,
// status and last, each shown for exactly one cycle while strobe is high.
// The receiver cannot stall the block, so every result must be taken when
// it is shown.
// Push, query, the unused mode codes and every empty or full answer give
// their single result in the cycle after acceptance and leave busy low, so
// such commands may follow each other in every cycle.
// A pop reads the slot memory, whose read data is registered, and gives its
// result from the ST_POP state after acceptance; busy is high for one cycle.
// A list of N elements reads one slot per cycle from the memory port and
// gives its results in order from the front, with last on the back element;
// busy stays high while ST_LIST runs.
// Reset empties the queue and clears the running sum; the slots themselves
// are not cleared, and no clearing pass is needed.
module double_ended_queue_with_sum_top #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [deq_pkg::MODE_W-1:0]         mode,
  input  logic signed [deq_pkg::DATA_W-1:0]  value,
  output logic                               busy,
  output logic                               strobe,
  output logic signed [deq_pkg::DATA_W-1:0]  item,
  output logic [deq_pkg::CNT_W-1:0]          entries,
  output logic signed [deq_pkg::DATA_W-1:0]  total,
  output logic [deq_pkg::STAT_W-1:0]         status,
  output logic                               last
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_LIST = 3'b100
  } state_t;

  state_t state;
  logic [IW-1:0] front;
  logic [CNT_W-1:0] count;
  logic signed [DATA_W-1:0] sum;
  logic [IW-1:0] walk;
  logic [CNT_W-1:0] remain;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic we;

  logic accept;
  logic full;
  logic empty;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] back_pos;
  logic [IW-1:0] tail_pos;
  logic [IW-1:0] walk_inc;

  deq_addr #(.DEPTH(DEPTH)) u_addr (
    .front     (front),
    .count     (count),
    .walk      (walk),
    .front_inc (front_inc),
    .front_dec (front_dec),
    .back_pos  (back_pos),
    .tail_pos  (tail_pos),
    .walk_inc  (walk_inc)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count >= CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    raddr = front;
    if (state == ST_LIST) begin
      raddr = walk;
    end else if (mode == MODE_POP_BACK) begin
      raddr = tail_pos;
    end
  end

  assign we = accept && !full && ((mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK));
  assign waddr = (mode == MODE_PUSH_FRONT) ? front_dec : back_pos;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= value;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      front  <= '0;
      count  <= '0;
      sum    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_LIST: begin
                if (empty) begin
                  strobe  <= 1'b1;
                  item    <= '0;
                  entries <= count;
                  total   <= sum;
                  status  <= STAT_EMPTY;
                  last    <= 1'b1;
                end else begin
                  walk   <= front_inc;
                  remain <= count;
                  state  <= ST_LIST;
                end
              end
              MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                strobe <= 1'b1;
                item   <= value;
                last   <= 1'b1;
                if (full) begin
                  entries <= count;
                  total   <= sum;
                  status  <= STAT_FULL;
                end else begin
                  if (mode == MODE_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                  count   <= count + CNT_W'(1);
                  sum     <= sum + value;
                  entries <= count + CNT_W'(1);
                  total   <= sum + value;
                  status  <= STAT_OK;
                end
              end
              MODE_POP_FRONT, MODE_POP_BACK: begin
                if (empty) begin
                  strobe  <= 1'b1;
                  item    <= '0;
                  entries <= count;
                  total   <= sum;
                  status  <= STAT_EMPTY;
                  last    <= 1'b1;
                end else begin
                  if (mode == MODE_POP_FRONT) begin
                    front <= front_inc;
                  end
                  state <= ST_POP;
                end
              end
              default: begin
                strobe  <= 1'b1;
                item    <= '0;
                entries <= count;
                total   <= sum;
                status  <= STAT_OK;
                last    <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          count   <= count - CNT_W'(1);
          sum     <= sum - rdata;
          strobe  <= 1'b1;
          item    <= rdata;
          entries <= count - CNT_W'(1);
          total   <= sum - rdata;
          status  <= STAT_OK;
          last    <= 1'b1;
          state   <= ST_IDLE;
        end
        ST_LIST: begin
          strobe  <= 1'b1;
          item    <= rdata;
          entries <= count;
          total   <= sum;
          status  <= STAT_OK;
          last    <= (remain == CNT_W'(1));
          walk    <= walk_inc;
          remain  <= remain - CNT_W'(1);
          if (remain == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds the queue depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == STAT_FULL)) |-> (entries == CNT_W'(DEPTH)))
    else $error("full status reported on a queue that is not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == STAT_EMPTY)) |-> (entries == '0))
    else $error("empty status reported on a queue that holds elements");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (strobe && last))
    else $error("busy dropped without a final result word");

  a_pop_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (state == ST_IDLE))
    else $error("pop did not complete in one cycle");

endmodule

>>> tb/double_ended_queue_with_sum_top_tb.sv
// Self-checking testbench for double_ended_queue_with_sum_top.
// It drives command words, takes result words from its deque model or typed table rows
// and checks them in order. Depends on deq_pkg and the top-level RTL.
module double_ended_queue_with_sum_top_tb;
  import deq_pkg::*;

  localparam int DEPTH = 64;
  localparam int IW = $clog2(DEPTH);
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = DEPTH + 4;
  localparam int TARGET_COMMANDS = 410;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [CNT_W-1:0]         entries;
    logic signed [DATA_W-1:0] total;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } word_t;

  typedef struct packed {
    logic [MODE_W-1:0]        op;
    logic signed [DATA_W-1:0] arg;
    logic                     typed;
    word_t                    want;
  } step_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [MODE_W-1:0]        mode = MODE_QUERY;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic signed [DATA_W-1:0] item;
  logic [CNT_W-1:0]         entries;
  logic signed [DATA_W-1:0] total;
  logic [STAT_W-1:0]        status;
  logic                     last;

  logic signed [DATA_W-1:0] shadow_slot [DEPTH];
  int                       shadow_front = 0;
  int                       shadow_count = 0;
  logic signed [DATA_W-1:0] shadow_sum = '0;
  word_t                    pending_words [$];

  int errors = 0;
  int commands_sent = 0;
  int words_checked = 0;
  int full_drops = 0;
  int empty_answers = 0;
  int peak_fill = 0;
  int quiet_cycles = 0;

  // Rows with typed set carry their result word; all others use the predictor.
  step_t directed_steps [23] = '{
    '{MODE_QUERY,      32'sd0,         1'b1, '{32'sd0, 7'd0, 32'sd0, STAT_OK, 1'b1}},
    '{MODE_LIST,       32'sd0,         1'b1, '{32'sd0, 7'd0, 32'sd0, STAT_EMPTY, 1'b1}},
    '{MODE_POP_FRONT,  32'sh12345678,  1'b1, '{32'sd0, 7'd0, 32'sd0, STAT_EMPTY, 1'b1}},
    '{MODE_POP_BACK,   32'shFFFFFFFF,  1'b1, '{32'sd0, 7'd0, 32'sd0, STAT_EMPTY, 1'b1}},
    '{MODE_PUSH_BACK,  32'sh7FFFFFFF,  1'b1,
      '{32'sh7FFFFFFF, 7'd1, 32'sh7FFFFFFF, STAT_OK, 1'b1}},
    '{MODE_PUSH_FRONT, 32'sh80000000,  1'b1,
      '{32'sh80000000, 7'd2, 32'shFFFFFFFF, STAT_OK, 1'b1}},
    '{MODE_PUSH_BACK,  32'shFFFFFFFF,  1'b1,
      '{32'shFFFFFFFF, 7'd3, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_PUSH_FRONT, 32'sd0,         1'b1, '{32'sd0, 7'd4, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_LIST,       32'sd0,         1'b0, '0},
    '{MODE_SPARE_6,    32'sh55555555,  1'b1, '{32'sd0, 7'd4, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_SPARE_7,    32'shAAAAAAAA,  1'b1, '{32'sd0, 7'd4, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_QUERY,      32'shFFFFFFFF,  1'b1, '{32'sd0, 7'd4, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_POP_FRONT,  32'sd0,         1'b1, '{32'sd0, 7'd3, 32'shFFFFFFFE, STAT_OK, 1'b1}},
    '{MODE_POP_BACK,   32'sd0,         1'b1,
      '{32'shFFFFFFFF, 7'd2, 32'shFFFFFFFF, STAT_OK, 1'b1}},
    '{MODE_LIST,       32'sd0,         1'b0, '0},
    '{MODE_POP_FRONT,  32'sd0,         1'b1,
      '{32'sh80000000, 7'd1, 32'sh7FFFFFFF, STAT_OK, 1'b1}},
    '{MODE_POP_BACK,   32'sd0,         1'b1, '{32'sh7FFFFFFF, 7'd0, 32'sd0, STAT_OK, 1'b1}},
    '{MODE_PUSH_FRONT, 32'sd1,         1'b0, '0},
    '{MODE_PUSH_BACK,  32'shDEADBEEF,  1'b0, '0},
    '{MODE_PUSH_FRONT, 32'sd7,         1'b0, '0},
    '{MODE_LIST,       32'sd0,         1'b0, '0},
    '{MODE_POP_BACK,   32'sd0,         1'b0, '0},
    '{MODE_POP_FRONT,  32'sd0,         1'b0, '0}
  };

  double_ended_queue_with_sum_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .mode(mode),
    .value(value),
    .busy(busy),
    .strobe(strobe),
    .item(item),
    .entries(entries),
    .total(total),
    .status(status),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void log_word(logic signed [DATA_W-1:0] it, logic [STAT_W-1:0] st,
                                   logic lst);
    word_t w;
    w.item = it;
    w.entries = shadow_count[CNT_W-1:0];
    w.total = shadow_sum;
    w.status = st;
    w.last = lst;
    pending_words.push_back(w);
    if (st == STAT_FULL) full_drops++;
    if (st == STAT_EMPTY) empty_answers++;
  endfunction

  function automatic void deque_apply(logic [MODE_W-1:0] op, logic signed [DATA_W-1:0] arg);
    int pos;
    logic signed [DATA_W-1:0] got;
    case (op)
      MODE_LIST: begin
        if (shadow_count == 0) begin
          log_word('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            log_word(shadow_slot[IW'((shadow_front + i) % DEPTH)], STAT_OK,
                     i == shadow_count - 1);
        end
      end
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          log_word(arg, STAT_FULL, 1'b1);
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            pos = shadow_front;
          end else begin
            pos = (shadow_front + shadow_count) % DEPTH;
          end
          shadow_slot[IW'(pos)] = arg;
          shadow_count++;
          shadow_sum = shadow_sum + arg;
          if (shadow_count > peak_fill) peak_fill = shadow_count;
          log_word(arg, STAT_OK, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_count == 0) begin
          log_word('0, STAT_EMPTY, 1'b1);
        end else begin
          if (op == MODE_POP_FRONT) begin
            pos = shadow_front;
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            pos = (shadow_front + shadow_count - 1) % DEPTH;
          end
          got = shadow_slot[IW'(pos)];
          shadow_count--;
          shadow_sum = shadow_sum - got;
          log_word(got, STAT_OK, 1'b1);
        end
      end
      default: begin
        log_word('0, STAT_OK, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (!rst && strobe) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, item %0h", $time, item);
      end else begin
        want = pending_words.pop_front();
        check_field("item", want.item, item);
        check_field("entries", DATA_W'(want.entries), DATA_W'(entries));
        check_field("total", want.total, total);
        check_field("status", DATA_W'(want.status), DATA_W'(status));
        check_field("last", DATA_W'(want.last), DATA_W'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL double_ended_queue_with_sum_top");
        $finish;
      end
    end
  end

  task automatic send(logic [MODE_W-1:0] op, logic signed [DATA_W-1:0] arg, logic typed,
                      word_t want);
    int idle_pct;
    idle_pct = (commands_sent < 170) ? 0 : (commands_sent < 300) ? 67 : 23;
    start <= 1'b1;
    mode <= op;
    value <= arg;
    do @(posedge clk); while (busy);
    commands_sent++;
    deque_apply(op, arg);
    if (typed) begin
      void'(pending_words.pop_back());
      pending_words.push_back(want);
    end
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] any_value();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return 32'sh7FFFFFFF;
      3: return 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] any_end_push();
    return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
  endfunction

  function automatic logic [MODE_W-1:0] any_end_pop();
    return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  function automatic logic [MODE_W-1:0] any_quiet_op();
    case ($urandom_range(3))
      0: return MODE_LIST;
      1: return MODE_QUERY;
      2: return MODE_SPARE_6;
      default: return MODE_SPARE_7;
    endcase
  endfunction

  task automatic fill_queue();
    while (shadow_count < DEPTH && commands_sent < TARGET_COMMANDS) begin
      if ($urandom_range(99) < 90) send(any_end_push(), any_value(), 1'b0, '0);
      else send(any_quiet_op(), any_value(), 1'b0, '0);
    end
    repeat ($urandom_range(1, 3)) send(any_end_push(), any_value(), 1'b0, '0);
  endtask

  task automatic drain_queue();
    while (shadow_count > 0 && commands_sent < TARGET_COMMANDS) begin
      if ($urandom_range(99) < 90) send(any_end_pop(), any_value(), 1'b0, '0);
      else send(any_quiet_op(), any_value(), 1'b0, '0);
    end
    repeat ($urandom_range(1, 2)) send(any_end_pop(), any_value(), 1'b0, '0);
  endtask

  task automatic mixed_ops(int count);
    for (int n = 0; n < count && commands_sent < TARGET_COMMANDS; n++)
      send(MODE_W'($urandom_range(7)), any_value(), 1'b0, '0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_steps[k])
      send(directed_steps[k].op, directed_steps[k].arg, directed_steps[k].typed,
           directed_steps[k].want);
    while (commands_sent < TARGET_COMMANDS) begin
      fill_queue();
      mixed_ops(20);
      drain_queue();
      mixed_ops(20);
    end
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d commands and checked %0d result words, %0d mismatches.",
             commands_sent, words_checked, errors);
    $display("Peak fill %0d of %0d, %0d pushes dropped when full, %0d empty answers.",
             peak_fill, DEPTH, full_drops, empty_answers);
    if (errors == 0) begin
      $display("PASS double_ended_queue_with_sum_top");
    end else begin
      $display("FAIL double_ended_queue_with_sum_top");
    end
    $finish;
  end

endmodule
